// File: hdl/rtrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrd_pkg: shared types and constants of the target report deframer
// Holds the frame constants, the result kind codes, the controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rtrd_pkg;

	localparam logic [7:0] SYNC_BYTE         = 8'h5A;
	localparam logic [7:0] REPORT_TYPE_RESET = 8'd7;
	localparam logic [7:0] RECORD_OFFSET     = 8'd4;

	typedef enum logic [2:0] {
		KIND_RECORD   = 3'd0,
		KIND_NONE     = 3'd1,
		KIND_OTHER    = 3'd2,
		KIND_CHECKSUM = 3'd3,
		KIND_SHORT    = 3'd4
	} rtrd_kind_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_TYPE,
		ST_LEN,
		ST_PAYLOAD,
		ST_CHECK,
		ST_FETCH,
		ST_SHOW
	} rtrd_state_t;

	typedef struct packed {
		logic start;
		logic take_type;
		logic take_len;
		logic take_payload;
		logic finish;
		logic fetch;
		logic advance;
	} rtrd_cmd_t;

	typedef struct packed {
		logic is_sync;
		logic len_zero;
		logic payload_end;
		logic has_records;
		logic last_item;
	} rtrd_stat_t;

endpackage
`default_nettype wire

// File: hdl/rtrd_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrd_byte_if: received byte channel
// Valid and ready handshake carrying one serial byte per transfer.
// ----------------------------------------------------------------------------
interface rtrd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/rtrd_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrd_item_if: result item channel
// Valid and ready handshake carrying one target record or status item.
// ----------------------------------------------------------------------------
interface rtrd_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [3:0]  target_index;
	logic [15:0] object_count;
	logic [7:0]  target_distance;
	logic [7:0]  target_speed;
	logic [7:0]  target_angle;
	logic [7:0]  target_spare;
	logic [7:0]  seen_type;
	logic        last_of_frame;

	modport source (
		output valid, output item_kind, output target_index, output object_count,
		output target_distance, output target_speed, output target_angle,
		output target_spare, output seen_type, output last_of_frame,
		input ready
	);
	modport sink (
		input valid, input item_kind, input target_index, input object_count,
		input target_distance, input target_speed, input target_angle,
		input target_spare, input seen_type, input last_of_frame,
		output ready
	);
endinterface
`default_nettype wire

// File: hdl/rtrd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrd_ctrl: frame controller
// Walks through sync, type, length, payload and checksum, then sequences
// the release of the result items.
// ----------------------------------------------------------------------------
module rtrd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire rtrd_pkg::rtrd_stat_t stat,
	output rtrd_pkg::rtrd_cmd_t       cmd
);
	import rtrd_pkg::*;

	rtrd_state_t state_q;
	rtrd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_HUNT: begin
				in_ready = 1'b1;
				if (in_valid && stat.is_sync) begin
					cmd.start = 1'b1;
					state_d   = ST_TYPE;
				end
			end
			ST_TYPE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_type = 1'b1;
					state_d       = ST_LEN;
				end
			end
			ST_LEN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_len = 1'b1;
					state_d      = stat.len_zero ? ST_CHECK : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_payload = 1'b1;
					if (stat.payload_end) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.finish = 1'b1;
					state_d    = stat.has_records ? ST_FETCH : ST_SHOW;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_SHOW;
			end
			ST_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.advance = 1'b1;
					state_d     = stat.last_item ? ST_HUNT : ST_FETCH;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/rtrd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrd_datapath: frame fields, checksum, record store and result register
// Accumulates the frame under controller command, judges the frame on the
// checksum byte and presents result items from its output registers.
// ----------------------------------------------------------------------------
module rtrd_datapath #(
	parameter int MAX_TARGETS = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [7:0]           cfg_wr_data,
	input  wire logic [7:0]           rx_byte,
	input  wire rtrd_pkg::rtrd_cmd_t  cmd,
	output rtrd_pkg::rtrd_stat_t      stat,
	output rtrd_pkg::rtrd_kind_t      item_kind,
	output logic [3:0]                target_index,
	output logic [15:0]               object_count,
	output logic [7:0]                target_distance,
	output logic [7:0]                target_speed,
	output logic [7:0]                target_angle,
	output logic [7:0]                target_spare,
	output logic [7:0]                seen_type,
	output logic                      last_of_frame
);
	import rtrd_pkg::*;

	localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CNT_W = $clog2(MAX_TARGETS + 1);

	logic [7:0]       type_code_q;
	logic [7:0]       frame_kind_q;
	logic [7:0]       length_q;
	logic [7:0]       position_q;
	logic [7:0]       sum_q;
	logic [15:0]      total_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] emit_idx_q;
	rtrd_kind_t       kind_q;
	logic [15:0]      out_count_q;
	logic             last_q;

	// Record store: one row per target, written a byte at a time.
	logic [7:0] store_q [0:MAX_TARGETS-1][0:3];
	logic [7:0] rd_q    [0:3];

	logic [8:0]  next_pos;
	logic [7:0]  rel;
	logic [5:0]  rec_idx;
	logic        rec_write;
	logic        sum_ok;
	logic        type_ok;
	logic        len_ok;
	logic [5:0]  cap;
	logic [15:0] lim;
	logic [15:0] n_rec;
	rtrd_kind_t  verdict;
	logic        records;

	assign next_pos  = {1'b0, position_q} + 9'd1;
	assign rel       = position_q - RECORD_OFFSET;
	assign rec_idx   = rel[7:2];
	assign rec_write = cmd.take_payload && (position_q >= RECORD_OFFSET)
		&& ({2'b00, rec_idx} < 8'(MAX_TARGETS));

	assign sum_ok  = (rx_byte == sum_q);
	assign type_ok = (frame_kind_q == type_code_q);
	assign len_ok  = (length_q >= RECORD_OFFSET);
	assign cap     = rel[7:2];
	assign lim     = (total_q > 16'(MAX_TARGETS)) ? 16'(MAX_TARGETS) : total_q;
	assign n_rec   = (lim > {10'b0, cap}) ? {10'b0, cap} : lim;

	always_comb begin
		records = 1'b0;
		if (!sum_ok) begin
			verdict = KIND_CHECKSUM;
		end else if (!type_ok) begin
			verdict = KIND_OTHER;
		end else if (!len_ok) begin
			verdict = KIND_SHORT;
		end else if (total_q == 16'd0) begin
			verdict = KIND_NONE;
		end else if (n_rec == 16'd0) begin
			verdict = KIND_SHORT;
		end else begin
			verdict = KIND_RECORD;
			records = 1'b1;
		end
	end

	assign stat.is_sync     = (rx_byte == SYNC_BYTE);
	assign stat.len_zero    = (rx_byte == 8'd0);
	assign stat.payload_end = (next_pos >= {1'b0, length_q});
	assign stat.has_records = records;
	assign stat.last_item   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_code_q  <= REPORT_TYPE_RESET;
			frame_kind_q <= 8'd0;
			length_q     <= 8'd0;
			position_q   <= 8'd0;
			sum_q        <= 8'd0;
			total_q      <= 16'd0;
		end else begin
			if (cfg_wr_en) begin
				type_code_q <= cfg_wr_data;
			end
			if (cmd.start) begin
				sum_q <= SYNC_BYTE;
			end
			if (cmd.take_type) begin
				frame_kind_q <= rx_byte;
				sum_q        <= sum_q + rx_byte;
			end
			if (cmd.take_len) begin
				length_q   <= rx_byte;
				position_q <= 8'd0;
				total_q    <= 16'd0;
				sum_q      <= sum_q + rx_byte;
			end
			if (cmd.take_payload) begin
				sum_q      <= sum_q + rx_byte;
				position_q <= next_pos[7:0];
				if (position_q == 8'd0) begin
					total_q[7:0] <= rx_byte;
				end else if (position_q == 8'd1) begin
					total_q[15:8] <= rx_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_write) begin
			store_q[rec_idx[IDX_W-1:0]][rel[1:0]] <= rx_byte;
		end
	end

	// Result registers; the read data of the store doubles as the output.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			kind_q     <= verdict;
			emit_idx_q <= '0;
			count_q    <= CNT_W'(n_rec);
			last_q     <= 1'b1;
			for (int i = 0; i < 4; i++) begin
				rd_q[i] <= 8'd0;
			end
			if (records || verdict == KIND_SHORT) begin
				out_count_q <= total_q;
			end else begin
				out_count_q <= 16'd0;
			end
		end
		if (cmd.fetch) begin
			rd_q   <= store_q[emit_idx_q[IDX_W-1:0]];
			last_q <= ((emit_idx_q + 1'b1) == count_q);
		end
		if (cmd.advance) begin
			emit_idx_q <= emit_idx_q + 1'b1;
		end
	end

	assign item_kind       = kind_q;
	assign target_index    = 4'(emit_idx_q);
	assign object_count    = out_count_q;
	assign target_distance = rd_q[0];
	assign target_speed    = rd_q[1];
	assign target_angle    = rd_q[2];
	assign target_spare    = rd_q[3];
	assign seen_type       = frame_kind_q;
	assign last_of_frame   = last_q;

endmodule
`default_nettype wire

// File: hdl/radar_target_report_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radar_target_report_deframer: target report frame parser
// Received serial bytes enter on the serial channel, one per transfer. The
// block hunts for the sync byte, then takes the type, length, payload and
// checksum bytes. While a frame is being parsed, the block accepts one
// byte transfer per clock. When the checksum byte is taken, the frame is
// judged. A bad checksum, a foreign type, a short payload or a zero object
// count produces one status item, shown on the report channel in the cycle
// after the checksum transfer. A good target report releases its buffered
// records one by one; each record is first read from the record store and
// then stays on the channel until it is transferred.
// The final item of a frame carries last_of_frame. While results are being
// released the serial channel is held not ready, so a receiver that stalls
// the report channel simply stretches this window; nothing is lost.
// The user writes the report type register through cfg_wr_en and cfg_wr_data
// only while the block is idle; the block does not enforce it. Reset returns
// the parser to hunting for sync and the report type to 7; the record store
// needs no clearing, since a frame only releases records that it wrote itself.
// ----------------------------------------------------------------------------
module radar_target_report_deframer #(
	parameter int MAX_TARGETS = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	rtrd_byte_if.sink       serial,
	rtrd_item_if.source     report
);
	import rtrd_pkg::*;

	rtrd_cmd_t  cmd;
	rtrd_stat_t stat;
	rtrd_kind_t kind;

	// The controller owns both handshakes; the datapath only follows commands.
	rtrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (serial.valid),
		.in_ready  (serial.ready),
		.out_valid (report.valid),
		.out_ready (report.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rtrd_datapath #(
		.MAX_TARGETS (MAX_TARGETS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.rx_byte         (serial.rx_byte),
		.cmd             (cmd),
		.stat            (stat),
		.item_kind       (kind),
		.target_index    (report.target_index),
		.object_count    (report.object_count),
		.target_distance (report.target_distance),
		.target_speed    (report.target_speed),
		.target_angle    (report.target_angle),
		.target_spare    (report.target_spare),
		.seen_type       (report.seen_type),
		.last_of_frame   (report.last_of_frame)
	);

	assign report.item_kind = kind;

endmodule
`default_nettype wire
